[rtl/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, register indexes and the side-band record that travels with
// each request through the spectral mask pipeline.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // Field and register widths.
    localparam int INDEX_W  = 12;
    localparam int SAMPLE_W = 32;
    localparam int CUTOFF_W = 16;
    localparam int DIM_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    // Weight format and filter order.
    localparam int WF           = 16;
    localparam int Q_ONE_BITS   = 30;
    localparam int FILTER_ORDER = 10;

    // Internal widths of the weight computation.
    localparam int DELTA_W = DIM_W;             // |2*index - size|
    localparam int SQ_W    = 2 * DELTA_W;       // one squared term
    localparam int DIST_W  = SQ_W + 1;          // dx^2 + dy^2
    localparam int SIZE_W  = 2 * DIM_W;         // rows^2 + cols^2
    localparam int C2_W    = 2 * CUTOFF_W;      // cutoff^2
    localparam int A_W     = C2_W + SIZE_W;     // cutoff^2 * S
    localparam int WIDE_W  = DIST_W + 32;       // D * 2^32
    localparam int NORM_W  = 33;                // operands after scaling
    localparam int SH_W    = 5;
    localparam int X_W     = Q_ONE_BITS + 1;    // Q0.30 ratio, up to 1.0
    localparam int DEN_W   = Q_ONE_BITS + 2;    // 2^30 + p
    localparam int W_W     = WF + 1;            // Q1.16 weight

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 2'd2;

    // Side-band record carried alongside each request.
    typedef struct packed {
        logic                       centre;
        logic                       zero_cut;
        logic                       a_ge_b;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } bsm_side_t;

endpackage

[rtl/bsm_geom.sv]
// ----------------------------------------------------------------------------
// bsm_geom
// Distance and size terms of a bin, the ratio operands and their scaling so
// that the larger operand fits in 33 bits. Six register stages.
// ----------------------------------------------------------------------------
module bsm_geom (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [bsm_pkg::INDEX_W-1:0]           row,
    input  logic [bsm_pkg::INDEX_W-1:0]           col,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0]   re,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0]   im,
    input  logic [bsm_pkg::CUTOFF_W-1:0]          cutoff,
    input  logic [bsm_pkg::DIM_W-1:0]             rows,
    input  logic [bsm_pkg::DIM_W-1:0]             cols,
    output logic                                  out_valid,
    output logic [bsm_pkg::NORM_W-1:0]            out_big,
    output logic [bsm_pkg::NORM_W-1:0]            out_small,
    output bsm_pkg::bsm_side_t                    out_side
);
    import bsm_pkg::*;

    logic [5:0] valid_reg;
    logic [5:0] valid_next;

    // Stage 1 registers.
    logic [DELTA_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]    rr_reg, cc_reg;
    logic [C2_W-1:0]    c2_reg;
    bsm_side_t          side1_reg;
    // Stage 2 registers.
    logic [SQ_W-1:0]    dx2_reg, dy2_reg;
    logic [SIZE_W-1:0]  s_reg;
    logic [C2_W-1:0]    c2b_reg;
    bsm_side_t          side2_reg;
    // Stage 3 registers.
    logic [DIST_W-1:0]  d_reg;
    logic [A_W-1:0]     a_reg;
    bsm_side_t          side3_reg;
    // Stage 4 registers.
    logic [WIDE_W-1:0]  big_reg, small_reg;
    bsm_side_t          side4_reg;
    // Stage 5 registers.
    logic [WIDE_W-1:0]  big5_reg, small5_reg;
    logic [SH_W-1:0]    sh_reg;
    bsm_side_t          side5_reg;
    // Stage 6 registers.
    logic [NORM_W-1:0]  big6_reg, small6_reg;
    bsm_side_t          side6_reg;

    // Combinational terms.
    logic [DELTA_W-1:0] col2, row2;
    logic [DELTA_W-1:0] dx_next, dy_next;
    logic [WIDE_W-1:0]  a_wide, b_wide;
    logic               a_ge_b;
    logic [SH_W-1:0]    sh_next;
    bsm_side_t          side1_next, side4_next;

    // Doubled coordinates against the frame size.
    always_comb
    begin
        col2 = {col, 1'b0};
        row2 = {row, 1'b0};
        dx_next = (col2 >= cols) ? (col2 - cols) : (cols - col2);
        dy_next = (row2 >= rows) ? (row2 - rows) : (rows - row2);
        side1_next          = '0;
        side1_next.re       = re;
        side1_next.im       = im;
    end

    // Ratio operands A = cutoff^2 * S and B = D * 2^32.
    always_comb
    begin
        a_wide = WIDE_W'(a_reg);
        b_wide = {d_reg, 32'd0};
        a_ge_b = (a_wide >= b_wide);
        side4_next          = side3_reg;
        side4_next.centre   = (d_reg == '0);
        side4_next.zero_cut = (a_reg == '0);
        side4_next.a_ge_b   = a_ge_b;
    end

    // Right shift that brings the larger operand below 2^33.
    always_comb
    begin
        sh_next = '0;
        for (int i = NORM_W; i < WIDE_W; i++)
        begin
            if (big_reg[i])
            begin
                sh_next = SH_W'(i - NORM_W + 1);
            end
        end
    end

    // Valid bits.
    assign valid_next = {valid_reg[4:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        rr_reg     <= rows * rows;
        cc_reg     <= cols * cols;
        c2_reg     <= cutoff * cutoff;
        side1_reg  <= side1_next;

        dx2_reg    <= dx_reg * dx_reg;
        dy2_reg    <= dy_reg * dy_reg;
        s_reg      <= SIZE_W'(rr_reg) + SIZE_W'(cc_reg);
        c2b_reg    <= c2_reg;
        side2_reg  <= side1_reg;

        d_reg      <= DIST_W'(dx2_reg) + DIST_W'(dy2_reg);
        a_reg      <= A_W'(c2b_reg) * A_W'(s_reg);
        side3_reg  <= side2_reg;

        big_reg    <= a_ge_b ? a_wide : b_wide;
        small_reg  <= a_ge_b ? b_wide : a_wide;
        side4_reg  <= side4_next;

        big5_reg   <= big_reg;
        small5_reg <= small_reg;
        sh_reg     <= sh_next;
        side5_reg  <= side4_reg;

        big6_reg   <= NORM_W'(big5_reg >> sh_reg);
        small6_reg <= NORM_W'(small5_reg >> sh_reg);
        side6_reg  <= side5_reg;
    end

    assign out_valid = valid_reg[5];
    assign out_big   = big6_reg;
    assign out_small = small6_reg;
    assign out_side  = side6_reg;

endmodule

[rtl/bsm_div.sv]
// ----------------------------------------------------------------------------
// bsm_div
// Pipelined restoring divider, one quotient bit per stage. The first stage
// compares the given remainder as is; later stages shift in a zero.
// ----------------------------------------------------------------------------
module bsm_div #(
    parameter int DIV_W = 33,
    parameter int Q_W   = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [DIV_W-1:0]       in_rem,
    input  logic [DIV_W-1:0]       in_den,
    input  bsm_pkg::bsm_side_t     in_side,
    output logic                   out_valid,
    output logic [Q_W-1:0]         out_quo,
    output bsm_pkg::bsm_side_t     out_side
);
    import bsm_pkg::*;

    logic [Q_W-1:0]   valid_reg;
    logic [DIV_W-1:0] rem_reg  [0:Q_W-1];
    logic [DIV_W-1:0] den_reg  [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg  [0:Q_W-1];
    bsm_side_t        side_reg [0:Q_W-1];

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DIV_W-1:0] rem_prev;
        logic [DIV_W-1:0] den_prev;
        logic [Q_W-1:0]   quo_prev;
        bsm_side_t        side_prev;
        logic [DIV_W:0]   trial;
        logic             take;
        logic [DIV_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = in_rem;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
            assign side_prev = in_side;
            assign trial     = {1'b0, rem_prev};
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign trial     = {rem_prev, 1'b0};
        end

        // Compare and subtract for this quotient bit.
        always_comb
        begin
            take     = (trial >= {1'b0, den_prev});
            rem_next = take ? DIV_W'(trial - {1'b0, den_prev}) : DIV_W'(trial);
            quo_next = quo_prev;
            quo_next[Q_W-1-k] = take;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_prev;
            quo_reg[k]  <= quo_next;
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

[rtl/bsm_pow.sv]
// ----------------------------------------------------------------------------
// bsm_pow
// Raises the Q0.30 ratio to the filter order by a chain of multipliers, one
// registered multiply per stage, each product truncated back to Q0.30.
// ----------------------------------------------------------------------------
module bsm_pow (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [bsm_pkg::X_W-1:0]       in_x,
    input  bsm_pkg::bsm_side_t            in_side,
    output logic                          out_valid,
    output logic [bsm_pkg::X_W-1:0]       out_p,
    output bsm_pkg::bsm_side_t            out_side
);
    import bsm_pkg::*;

    localparam int STAGES = FILTER_ORDER - 1;

    if (STAGES == 0)
    begin : g_none
        assign out_valid = in_valid;
        assign out_p     = in_x;
        assign out_side  = in_side;
    end
    else
    begin : g_chain
        logic [STAGES-1:0] valid_reg;
        logic [X_W-1:0]    x_reg    [0:STAGES-1];
        logic [X_W-1:0]    p_reg    [0:STAGES-1];
        bsm_side_t         side_reg [0:STAGES-1];

        // Valid bits.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= '0;
            end
            else
            begin
                valid_reg <= STAGES'({valid_reg, in_valid});
            end
        end

        for (genvar k = 0; k < STAGES; k++)
        begin : g_mul
            logic [X_W-1:0]   x_prev;
            logic [X_W-1:0]   p_prev;
            bsm_side_t        side_prev;
            logic [2*X_W-1:0] prod;

            // The first power is the ratio itself.
            if (k == 0)
            begin : g_first
                assign x_prev    = in_x;
                assign p_prev    = in_x;
                assign side_prev = in_side;
            end
            else
            begin : g_next
                assign x_prev    = x_reg[k-1];
                assign p_prev    = p_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            assign prod = p_prev * x_prev;

            always_ff @(posedge clk)
            begin
                x_reg[k]    <= x_prev;
                p_reg[k]    <= prod[Q_ONE_BITS +: X_W];
                side_reg[k] <= side_prev;
            end
        end

        assign out_valid = valid_reg[STAGES-1];
        assign out_p     = p_reg[STAGES-1];
        assign out_side  = side_reg[STAGES-1];
    end

endmodule

[rtl/bsm_scale.sv]
// ----------------------------------------------------------------------------
// bsm_scale
// Applies the special cases to the weight and scales both parts of the bin
// by it on magnitudes, truncating toward zero. Three register stages.
// ----------------------------------------------------------------------------
module bsm_scale (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [bsm_pkg::W_W-1:0]               in_w,
    input  bsm_pkg::bsm_side_t                    in_side,
    output logic                                  out_valid,
    output logic signed [bsm_pkg::SAMPLE_W-1:0]   out_re,
    output logic signed [bsm_pkg::SAMPLE_W-1:0]   out_im
);
    import bsm_pkg::*;

    localparam int HI_W   = SAMPLE_W - WF;
    localparam int PROD_W = SAMPLE_W + 1;

    logic [2:0]          valid_reg;
    // Stage 1.
    logic [W_W-1:0]      w_reg;
    logic [SAMPLE_W-1:0] mag_re_reg, mag_im_reg;
    logic [1:0]          neg1_reg;
    // Stage 2.
    logic [PROD_W-1:0]   hi_re_reg, lo_re_reg, hi_im_reg, lo_im_reg;
    logic [1:0]          neg2_reg;
    // Stage 3.
    logic [SAMPLE_W-1:0] re_reg, im_reg;

    logic [W_W-1:0]      w_next;
    logic [PROD_W-1:0]   sum_re, sum_im;

    // Centre passes unchanged; zero cutoff or frame blanks the bin.
    always_comb
    begin
        priority if (in_side.centre)
        begin
            w_next = W_W'(1) << WF;
        end
        else if (in_side.zero_cut)
        begin
            w_next = '0;
        end
        else
        begin
            w_next = in_w;
        end
    end

    // Recombine the partial products.
    always_comb
    begin
        sum_re = hi_re_reg + (lo_re_reg >> WF);
        sum_im = hi_im_reg + (lo_im_reg >> WF);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        mag_re_reg <= in_side.re[SAMPLE_W-1] ? SAMPLE_W'(-in_side.re) : in_side.re;
        mag_im_reg <= in_side.im[SAMPLE_W-1] ? SAMPLE_W'(-in_side.im) : in_side.im;
        neg1_reg   <= {in_side.re[SAMPLE_W-1], in_side.im[SAMPLE_W-1]};

        hi_re_reg  <= PROD_W'(mag_re_reg[SAMPLE_W-1 -: HI_W]) * PROD_W'(w_reg);
        lo_re_reg  <= PROD_W'(mag_re_reg[WF-1:0]) * PROD_W'(w_reg);
        hi_im_reg  <= PROD_W'(mag_im_reg[SAMPLE_W-1 -: HI_W]) * PROD_W'(w_reg);
        lo_im_reg  <= PROD_W'(mag_im_reg[WF-1:0]) * PROD_W'(w_reg);
        neg2_reg   <= neg1_reg;

        re_reg     <= neg2_reg[1] ? SAMPLE_W'(-sum_re) : SAMPLE_W'(sum_re);
        im_reg     <= neg2_reg[0] ? SAMPLE_W'(-sum_im) : SAMPLE_W'(sum_im);
    end

    assign out_valid = valid_reg[2];
    assign out_re    = re_reg;
    assign out_im    = im_reg;

endmodule

[rtl/butterworth_spectral_mask.sv]
// ----------------------------------------------------------------------------
// butterworth_spectral_mask
// Order-10 Butterworth low-pass weight applied to bins of a centred spectrum.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high; busy never rises.
// Each request returns its scaled bin with done high for one cycle, in
// request order. The pipeline is made of the two pipelined dividers
// (31 stages for the distance ratio, 17 for the weight), the nine-stage
// multiplier chain for the tenth power, six stages of geometry and three of
// scaling. The receiver has no way to stall and needs none. Configuration
// writes are always accepted and must only be made while no request is in
// flight.
module butterworth_spectral_mask (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [bsm_pkg::INDEX_W-1:0]           row_index,
    input  logic [bsm_pkg::INDEX_W-1:0]           col_index,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0]   bin_real,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0]   bin_imag,
    output logic                                  done,
    output logic signed [bsm_pkg::SAMPLE_W-1:0]   scaled_real,
    output logic signed [bsm_pkg::SAMPLE_W-1:0]   scaled_imag,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import bsm_pkg::*;

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [DIM_W-1:0]    rows_reg, cols_reg;
    logic [DIM_W-1:0]    dim_in;

    logic                geo_valid;
    logic [NORM_W-1:0]   geo_big, geo_small;
    bsm_side_t           geo_side;
    logic                x_valid;
    logic [X_W-1:0]      x_quo;
    bsm_side_t           x_side;
    logic                p_valid;
    logic [X_W-1:0]      p_val;
    bsm_side_t           p_side;
    logic [DEN_W-1:0]    w_rem, w_den;
    logic                w_valid;
    logic [W_W-1:0]      w_quo;
    bsm_side_t           w_side;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Frame sizes above the maximum saturate.
    assign dim_in = (cfg_data[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : cfg_data[DIM_W-1:0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= 16'd32768;
            rows_reg   <= 13'd512;
            cols_reg   <= 13'd512;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CUTOFF:    cutoff_reg <= cfg_data;
                REG_ROWS_USED: rows_reg   <= dim_in;
                REG_COLS_USED: cols_reg   <= dim_in;
                default:       ;
            endcase
        end
    end

    // Distance and ratio operands.
    bsm_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .row       (row_index),
        .col       (col_index),
        .re        (bin_real),
        .im        (bin_imag),
        .cutoff    (cutoff_reg),
        .rows      (rows_reg),
        .cols      (cols_reg),
        .out_valid (geo_valid),
        .out_big   (geo_big),
        .out_small (geo_small),
        .out_side  (geo_side)
    );

    // Q0.30 ratio of the smaller to the larger operand.
    bsm_div #(
        .DIV_W (NORM_W),
        .Q_W   (X_W)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_rem    (geo_small),
        .in_den    (geo_big),
        .in_side   (geo_side),
        .out_valid (x_valid),
        .out_quo   (x_quo),
        .out_side  (x_side)
    );

    // Ratio to the filter order.
    bsm_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_valid),
        .in_x      (x_quo),
        .in_side   (x_side),
        .out_valid (p_valid),
        .out_p     (p_val),
        .out_side  (p_side)
    );

    // Weight is 1/(1+p) inside the cutoff and p/(1+p) outside it.
    assign w_den = (DEN_W'(1) << Q_ONE_BITS) + DEN_W'(p_val);
    assign w_rem = p_side.a_ge_b ? (DEN_W'(1) << Q_ONE_BITS) : DEN_W'(p_val);

    bsm_div #(
        .DIV_W (DEN_W),
        .Q_W   (W_W)
    ) u_weight_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_rem    (w_rem),
        .in_den    (w_den),
        .in_side   (p_side),
        .out_valid (w_valid),
        .out_quo   (w_quo),
        .out_side  (w_side)
    );

    // Scaling of both parts.
    bsm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w_valid),
        .in_w      (w_quo),
        .in_side   (w_side),
        .out_valid (done),
        .out_re    (scaled_real),
        .out_im    (scaled_imag)
    );

endmodule

[dv/butterworth_spectral_mask_checker.sv]
// ----------------------------------------------------------------------------
// butterworth_spectral_mask_checker
// Watches the request, result and register channels of the spectral mask,
// predicts each scaled bin from its own copy of the registers and compares
// every result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module butterworth_spectral_mask_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [bsm_pkg::INDEX_W-1:0]         row_index,
    input  logic [bsm_pkg::INDEX_W-1:0]         col_index,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0] bin_real,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0] bin_imag,
    input  logic                                done,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0] scaled_real,
    input  logic signed [bsm_pkg::SAMPLE_W-1:0] scaled_imag,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  bins_pending,
    output int                                  bins_checked
);
    import bsm_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } scaled_bin_t;

    localparam longint unsigned Q30 = 64'd1 << Q_ONE_BITS;

    // Shadow copy of the configuration registers.
    longint unsigned cut_q;
    longint unsigned rows_q;
    longint unsigned cols_q;

    scaled_bin_t scaled_bins_due[$];

    // Butterworth weight of one bin as unsigned Q1.16.
    function automatic longint unsigned bin_weight(longint unsigned row, longint unsigned col);
        longint unsigned dx, dy, d, s, a, b, big, sml, x, p, den;
        dx = (2 * col >= cols_q) ? 2 * col - cols_q : cols_q - 2 * col;
        dy = (2 * row >= rows_q) ? 2 * row - rows_q : rows_q - 2 * row;
        d  = dx * dx + dy * dy;
        s  = rows_q * rows_q + cols_q * cols_q;
        if (d == 0)
            return 64'd1 << WF;
        while (d >= Q30 || s >= Q30)
        begin
            d = d >> 1;
            s = s >> 1;
        end
        a = cut_q * cut_q * s;
        if (a == 0)
            return 0;
        b   = d << 32;
        big = (a >= b) ? a : b;
        sml = (a >= b) ? b : a;
        while (big >= (64'd1 << 33))
        begin
            big = big >> 1;
            sml = sml >> 1;
        end
        x = (sml << 30) / big;
        p = Q30;
        for (int i = 0; i < FILTER_ORDER; i++)
            p = (p * x) >> 30;
        den = Q30 + p;
        if (a >= b)
            return (Q30 << WF) / den;
        return (p << WF) / den;
    endfunction

    // Sign-magnitude product with the weight, truncated toward zero.
    function automatic logic signed [SAMPLE_W-1:0] scale_part(logic signed [SAMPLE_W-1:0] v,
                                                            longint unsigned w);
        longint unsigned mag, prod;
        mag  = v[SAMPLE_W-1] ? longint'(-longint'(v)) : longint'(v);
        prod = (mag >> WF) * w + (((mag & ((64'd1 << WF) - 1)) * w) >> WF);
        return v[SAMPLE_W-1] ? -prod[SAMPLE_W-1:0] : prod[SAMPLE_W-1:0];
    endfunction

    assign bins_pending = scaled_bins_due.size();

    // Track register writes, predict on each request, compare on each result.
    always @(posedge clk or negedge rst_n)
    begin
        longint unsigned w;
        longint unsigned dim;
        scaled_bin_t exp_bin;
        if (!rst_n)
        begin
            cut_q        <= 32768;
            rows_q       <= 512;
            cols_q       <= 512;
            fail_count   <= 0;
            bins_checked <= 0;
            scaled_bins_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dim = cfg_data & 16'h1FFF;
                if (dim > MAX_DIM)
                    dim = MAX_DIM;
                case (cfg_index)
                    REG_CUTOFF:    cut_q  <= cfg_data;
                    REG_ROWS_USED: rows_q <= dim;
                    REG_COLS_USED: cols_q <= dim;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                w = bin_weight(row_index, col_index);
                exp_bin.re = scale_part(bin_real, w);
                exp_bin.im = scale_part(bin_imag, w);
                scaled_bins_due.push_back(exp_bin);
            end
            if (done)
            begin
                if (scaled_bins_due.size() == 0)
                begin
                    $error("unexpected result re=%0d im=%0d", scaled_real, scaled_imag);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_bin = scaled_bins_due.pop_front();
                    bins_checked <= bins_checked + 1;
                    if (scaled_real !== exp_bin.re || scaled_imag !== exp_bin.im)
                        fail_count <= fail_count + 1;
                    if (scaled_real !== exp_bin.re)
                        $error("scaled_real expected %0d actual %0d", exp_bin.re, scaled_real);
                    if (scaled_imag !== exp_bin.im)
                        $error("scaled_imag expected %0d actual %0d", exp_bin.im, scaled_imag);
                end
            end
        end
    end

endmodule

[dv/butterworth_spectral_mask_tb.sv]
// ----------------------------------------------------------------------------
// butterworth_spectral_mask_tb
// Drives the spectral mask through a series of register settings, each with
// a few directed bins and a stretch of random bins under varying request
// gaps; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module butterworth_spectral_mask_tb;
    import bsm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES = 8;
    localparam int RANDOM_BINS = 230;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [INDEX_W-1:0]         row_index = '0;
    logic [INDEX_W-1:0]         col_index = '0;
    logic signed [SAMPLE_W-1:0] bin_real = '0;
    logic signed [SAMPLE_W-1:0] bin_imag = '0;
    logic                       done;
    logic signed [SAMPLE_W-1:0] scaled_real;
    logic signed [SAMPLE_W-1:0] scaled_imag;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int fail_count;
    int bins_pending;
    int bins_checked;
    int cycles = 0;
    int gap_pct = 0;
    int rows_cur = 512;
    int cols_cur = 512;

    // Register settings per phase: cutoff, rows, cols (raw 16-bit data).
    logic [15:0] phase_cut  [PHASES] = '{16'd32768, 16'd0, 16'd65535, 16'd12000,
                                         16'd40000, 16'd20000, 16'd30000, 16'd50000};
    logic [15:0] phase_rows [PHASES] = '{16'd512, 16'd512, 16'd64, 16'd7,
                                         16'd4096, 16'hFFFF, 16'd0, 16'd1};
    logic [15:0] phase_cols [PHASES] = '{16'd512, 16'd512, 16'd48, 16'd5,
                                         16'd4096, 16'd1, 16'd0, 16'd3};

    always #5 clk = ~clk;

    butterworth_spectral_mask DUT (.*);

    butterworth_spectral_mask_checker u_checker (.*);

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // One register write through the valid/ready channel.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One bin request; each cycle in front of it is idle with the gap odds.
    task automatic send_bin(logic [INDEX_W-1:0] r, logic [INDEX_W-1:0] c,
                            logic [31:0] re, logic [31:0] im);
        logic took;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        row_index <= r;
        col_index <= c;
        bin_real  <= re;
        bin_imag  <= im;
        do
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        while (!took);
    endtask

    function automatic int clamp_size(logic [15:0] v);
        int d;
        d = int'(v & 16'h1FFF);
        return (d > 4096) ? 4096 : d;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index(int size);
        if ($urandom_range(9) < 8)
            return (size > 4095) ? INDEX_W'($urandom_range(4095))
                                 : INDEX_W'($urandom_range(size));
        return INDEX_W'($urandom);
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            gap_pct = (ph < 3) ? 11 : (ph < 6) ? 54 : 0;

            // Registers change only once the pipeline has emptied.
            if (ph > 0)
            begin
                start <= 1'b0;
                while (bins_pending != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
                write_reg(REG_CUTOFF, phase_cut[ph]);
                write_reg(REG_ROWS_USED, phase_rows[ph]);
                write_reg(REG_COLS_USED, phase_cols[ph]);
                if (ph == 5)
                    write_reg(2'd3, 16'hFFFF);
                rows_cur = clamp_size(phase_rows[ph]);
                cols_cur = clamp_size(phase_cols[ph]);
            end

            // Centre bin, far corner and origin with extreme sample values.
            send_bin(INDEX_W'(rows_cur / 2), INDEX_W'(cols_cur / 2),
                     32'h8000_0000, 32'h7FFF_FFFF);
            send_bin(12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000);
            send_bin(12'h000, 12'h000, 32'hFFFF_FFFF, 32'h0000_0001);

            // Random bins, mostly inside the frame.
            for (int i = 0; i < RANDOM_BINS; i++)
                send_bin(rand_index(rows_cur), rand_index(cols_cur),
                         rand_sample(), rand_sample());
        end

        start <= 1'b0;
        while (bins_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d scaled bins over %0d register settings,", bins_checked, PHASES);
        $display("including zero cutoff, saturated and zero frame sizes and varied gaps.");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
